[sv/sfir_pkg.sv]
package sfir_pkg;

	// defaults for the top-level parameters
	localparam int TAPS_DEFAULT = 64;
	localparam int COEF_FRACTION_BITS_DEFAULT = 15;

	// configuration register map
	localparam int PADDR_W = 3;
	localparam logic REG_TAP_COUNT = 1'b0;
	localparam logic [6:0] TAP_COUNT_RESET = 7'd64;

	// request codes
	localparam logic ACTION_FRAME = 1'b0;
	localparam logic ACTION_COEF = 1'b1;

	// one request
	typedef struct packed {
		logic action;
		logic signed [15:0] left_sample;
		logic signed [15:0] right_sample;
		logic [5:0] coef_index;
		logic signed [15:0] coef_value;
	} req_t;

	// one result
	typedef struct packed {
		logic signed [15:0] left_out;
		logic signed [15:0] right_out;
		logic saturated;
	} res_t;

	// controls broadcast to every cell of the row
	typedef struct packed {
		logic delay_shift;
		logic load;
		logic coef_shift;
		logic coef_wr;
		logic [5:0] coef_idx;
		logic signed [15:0] coef_val;
		logic signed [15:0] sample;
	} cell_ctl_t;

	// controls from the sequencer to the multiply-accumulate unit
	typedef struct packed {
		logic valid;
		logic first;
		logic last;
	} mac_ctl_t;

endpackage

[sv/sfir_cell.sv]
module sfir_cell import sfir_pkg::*; #(
	parameter int IDX = 0,
	parameter int N_W = 7
) (
	input logic clk,
	input logic arst_n,
	input cell_ctl_t ctl,
	input logic [N_W-1:0] ring_n,
	input logic signed [15:0] next_delay,
	input logic signed [15:0] next_coef,
	input logic signed [15:0] head_delay,
	input logic signed [15:0] head_coef,
	output logic signed [15:0] delay_q,
	output logic signed [15:0] coef_q
);

	logic active;
	logic last;
	logic hit;

	// position of this cell within the ring in use
	assign active = IDX < int'(ring_n);
	assign last = IDX == int'(ring_n) - 1;
	assign hit = int'(ctl.coef_idx) == IDX;

	// sample and coefficient held by this cell, rotated toward the head
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q <= '0;
			coef_q <= '0;
		end else begin
			if (ctl.delay_shift && active) begin
				if (last) begin
					delay_q <= ctl.load ? ctl.sample : head_delay;
				end else begin
					delay_q <= next_delay;
				end
			end
			if (ctl.coef_wr && hit) begin
				coef_q <= ctl.coef_val;
			end else if (ctl.coef_shift && active) begin
				coef_q <= last ? head_coef : next_coef;
			end
		end
	end

endmodule

[sv/sfir_mac.sv]
module sfir_mac import sfir_pkg::*; #(
	parameter int TAPS = TAPS_DEFAULT,
	parameter int COEF_FRACTION_BITS = COEF_FRACTION_BITS_DEFAULT
) (
	input logic clk,
	input logic arst_n,
	input mac_ctl_t ctl,
	input logic signed [15:0] head_delay,
	input logic signed [15:0] head_coef,
	input logic take,
	output logic res_valid,
	output logic signed [15:0] right_out,
	output logic saturated
);

	localparam int ACC_W = 32 + $clog2(TAPS);
	localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(32'sd32767);
	localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(-32'sd32768);

	logic valid_s1;
	logic first_s1;
	logic last_s1;
	logic signed [31:0] prod_s1;
	logic signed [ACC_W-1:0] acc_q;
	logic done_s2;
	logic res_valid_q;
	logic signed [15:0] right_q;
	logic sat_q;
	logic signed [ACC_W-1:0] scaled;

	// product of the head cell pair
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			first_s1 <= 1'b0;
			last_s1 <= 1'b0;
		end else begin
			valid_s1 <= ctl.valid;
			first_s1 <= ctl.first;
			last_s1 <= ctl.last;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= head_delay * head_coef;
	end

	// running sum, restarted on the first tap
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s2 <= 1'b0;
		end else begin
			done_s2 <= valid_s1 && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			acc_q <= first_s1 ? ACC_W'(prod_s1) : acc_q + ACC_W'(prod_s1);
		end
	end

	// floor shift back to sample scale
	assign scaled = acc_q >>> COEF_FRACTION_BITS;

	// clip to 16 bits and hold until the sequencer takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (done_s2) begin
			res_valid_q <= 1'b1;
		end else if (take) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done_s2) begin
			if (scaled > SAT_HI) begin
				right_q <= 16'sh7fff;
				sat_q <= 1'b1;
			end else if (scaled < SAT_LO) begin
				right_q <= 16'sh8000;
				sat_q <= 1'b1;
			end else begin
				right_q <= scaled[15:0];
				sat_q <= 1'b0;
			end
		end
	end

	assign res_valid = res_valid_q;
	assign right_out = right_q;
	assign saturated = sat_q;

endmodule

[sv/stereo_fir_right_channel.sv]
// channel   direction  handshake               payload
// request   in         req_valid / req_ready   req_data (req_t)
// result    out        res_valid / res_ready   res_data (res_t)
// config    in         apb write, pready high  pwdata[6:0] -> tap_count
//
// a frame with n taps in use goes from acceptance to the result register through one
// load-and-rotate step, one multiply-accumulate per cell of the ring, and the product,
// sum and clip stages.
// after tap_count changes, the first frame first rotates the delay ring back to
// its stored order and forward again.
// a coefficient write is done on acceptance and gives no result.
// reset clears every cell and the write position and sets tap_count to 64.
// a request is taken while the previous result waits; a finished result stalls
// the sequencer only while the result register is full and res_ready is low.
module stereo_fir_right_channel import sfir_pkg::*; #(
	parameter int TAPS = TAPS_DEFAULT,
	parameter int COEF_FRACTION_BITS = COEF_FRACTION_BITS_DEFAULT
) (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_ready,
	input req_t req_data,
	output logic res_valid,
	input logic res_ready,
	output res_t res_data,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [PADDR_W-1:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);

	localparam int N_W = $clog2(TAPS + 1);
	localparam int IDX_W = (TAPS > 1) ? $clog2(TAPS) : 1;
	localparam int RESET_N = (int'(TAP_COUNT_RESET) > TAPS) ? TAPS : int'(TAP_COUNT_RESET);

	typedef enum logic [2:0] {
		S_IDLE,
		S_ALIGN_BACK,
		S_FIX,
		S_ALIGN_FWD,
		S_LOAD,
		S_MAC,
		S_DRAIN
	} state_t;

	state_t state_q;
	logic [6:0] tap_count_q;
	logic [N_W-1:0] n;
	logic [N_W-1:0] ring_n_q;
	logic [N_W-1:0] ring_size;
	logic [N_W-1:0] cnt_q;
	logic [IDX_W-1:0] wp_q;
	logic [N_W-1:0] wp_ext;
	logic [N_W-1:0] wp_inc;
	logic signed [15:0] left_q;
	logic signed [15:0] right_q;
	logic res_valid_q;
	res_t res_q;
	logic req_acc;
	logic take;
	cell_ctl_t cell_ctl;
	mac_ctl_t mac_ctl;
	logic mac_valid;
	logic signed [15:0] mac_right;
	logic mac_sat;
	logic signed [15:0] delay_w [TAPS];
	logic signed [15:0] coef_w [TAPS];

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_count_q <= TAP_COUNT_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_TAP_COUNT) begin
			tap_count_q <= pwdata[6:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_TAP_COUNT) ? {25'd0, tap_count_q} : 32'd0;

	// taps in use, clamped to 1..TAPS
	always_comb begin
		if (tap_count_q == 7'd0) begin
			n = N_W'(1);
		end else if (int'(tap_count_q) > TAPS) begin
			n = N_W'(TAPS);
		end else begin
			n = N_W'(tap_count_q);
		end
	end

	assign wp_ext = N_W'(wp_q);
	assign wp_inc = wp_ext + N_W'(1);

	assign req_ready = state_q == S_IDLE;
	assign req_acc = req_valid && req_ready;
	assign take = state_q == S_DRAIN && mac_valid && (!res_valid_q || res_ready);

	// ring size: the old size while undoing the old rotation
	assign ring_size = (state_q == S_ALIGN_BACK) ? ring_n_q : n;

	// controls for the cell row
	always_comb begin
		cell_ctl.delay_shift = state_q inside {S_ALIGN_BACK, S_ALIGN_FWD, S_LOAD, S_MAC};
		cell_ctl.load = state_q == S_LOAD;
		cell_ctl.coef_shift = state_q == S_MAC;
		cell_ctl.coef_wr = req_acc && req_data.action == ACTION_COEF;
		cell_ctl.coef_idx = req_data.coef_index;
		cell_ctl.coef_val = req_data.coef_value;
		cell_ctl.sample = right_q;
	end

	assign mac_ctl.valid = state_q == S_MAC;
	assign mac_ctl.first = cnt_q == n;
	assign mac_ctl.last = cnt_q == N_W'(1);

	// sequencer; the delay ring stays rotated left by the write position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ring_n_q <= N_W'(RESET_N);
			cnt_q <= '0;
			wp_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req_acc && req_data.action == ACTION_FRAME) begin
						left_q <= req_data.left_sample;
						right_q <= req_data.right_sample;
						if (ring_n_q != n) begin
							if (wp_q != '0) begin
								cnt_q <= ring_n_q - wp_ext;
								state_q <= S_ALIGN_BACK;
							end else begin
								state_q <= S_FIX;
							end
						end else begin
							state_q <= S_LOAD;
						end
					end
				end
				S_ALIGN_BACK: begin
					cnt_q <= cnt_q - N_W'(1);
					if (cnt_q == N_W'(1)) begin
						state_q <= S_FIX;
					end
				end
				S_FIX: begin
					ring_n_q <= n;
					if (wp_ext >= n) begin
						wp_q <= '0;
						state_q <= S_LOAD;
					end else if (wp_q == '0) begin
						state_q <= S_LOAD;
					end else begin
						cnt_q <= wp_ext;
						state_q <= S_ALIGN_FWD;
					end
				end
				S_ALIGN_FWD: begin
					cnt_q <= cnt_q - N_W'(1);
					if (cnt_q == N_W'(1)) begin
						state_q <= S_LOAD;
					end
				end
				S_LOAD: begin
					wp_q <= (wp_inc >= n) ? '0 : IDX_W'(wp_inc);
					cnt_q <= n;
					state_q <= S_MAC;
				end
				S_MAC: begin
					cnt_q <= cnt_q - N_W'(1);
					if (cnt_q == N_W'(1)) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					if (take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			// result register
			if (take) begin
				res_valid_q <= 1'b1;
				res_q.left_out <= left_q;
				res_q.right_out <= mac_right;
				res_q.saturated <= mac_sat;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign res_valid = res_valid_q;
	assign res_data = res_q;

	// row of cells, each holding one delay sample and one coefficient
	for (genvar c = 0; c < TAPS; c++) begin : g_cell
		localparam int NXT = (c == TAPS - 1) ? 0 : c + 1;
		sfir_cell #(
			.IDX(c),
			.N_W(N_W)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.ctl(cell_ctl),
			.ring_n(ring_size),
			.next_delay(delay_w[NXT]),
			.next_coef(coef_w[NXT]),
			.head_delay(delay_w[0]),
			.head_coef(coef_w[0]),
			.delay_q(delay_w[c]),
			.coef_q(coef_w[c])
		);
	end

	// multiply-accumulate on the head cell
	sfir_mac #(
		.TAPS(TAPS),
		.COEF_FRACTION_BITS(COEF_FRACTION_BITS)
	) u_mac (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(mac_ctl),
		.head_delay(delay_w[0]),
		.head_coef(coef_w[0]),
		.take(take),
		.res_valid(mac_valid),
		.right_out(mac_right),
		.saturated(mac_sat)
	);

endmodule
